### src/ple_pkg.sv
package ple_pkg;

	localparam int CAPACITY   = 32;
	localparam int DATA_WIDTH = 32;

	localparam int IDX_W   = $clog2(CAPACITY);
	localparam int CNT_W   = $clog2(CAPACITY + 1);
	localparam int KIND_W  = 3;
	localparam int VALUE_W = 32;
	localparam int POS_W   = 6;
	localparam int STAT_W  = 2;
	localparam int ECNT_W  = 6;
	localparam int ELEM_W  = 32;
	localparam int CMP_W   = (CNT_W + 1 > POS_W) ? CNT_W + 1 : POS_W;

	typedef logic [DATA_WIDTH-1:0] data_t;
	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [CNT_W-1:0]      cnt_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_INS_FRONT = 3'd0,
		KIND_INS_BACK  = 3'd1,
		KIND_INS_POS   = 3'd2,
		KIND_DEL_FRONT = 3'd3,
		KIND_DEL_BACK  = 3'd4,
		KIND_DEL_POS   = 3'd5,
		KIND_READ      = 3'd6
	} kind_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK     = 2'd0,
		STAT_BADPOS = 2'd1,
		STAT_EMPTY  = 2'd2,
		STAT_FULL   = 2'd3
	} stat_t;

	typedef enum logic [1:0] {
		OP_HOLD = 2'd0,
		OP_INS  = 2'd1,
		OP_DEL  = 2'd2,
		OP_ROT  = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		idx_t     idx;
		data_t    value;
	} cell_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_READ = 2'b10
	} state_t;

endpackage

### src/ple_if.sv
interface ple_req_if;
	import ple_pkg::*;
	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  kind;
	logic [VALUE_W-1:0] value;
	logic [POS_W-1:0]   position;

	modport source (output valid, kind, value, position, input ready);
	modport sink   (input valid, kind, value, position, output ready);
endinterface

interface ple_rsp_if;
	import ple_pkg::*;
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [ECNT_W-1:0] element_count;
	logic [ELEM_W-1:0] element;
	logic              last;

	modport source (output valid, status, element_count, element, last, input ready);
	modport sink   (input valid, status, element_count, element, last, output ready);
endinterface

### src/ple_cell.sv
module ple_cell
	import ple_pkg::*;
(
	input  logic      clk,
	input  cell_cmd_t cmd,
	input  idx_t      pos,
	input  data_t     left,
	input  data_t     right,
	input  data_t     head,
	output data_t     data
);

	data_t data_q;

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_INS: begin
				if (pos > cmd.idx) begin
					data_q <= left;
				end else if (pos == cmd.idx) begin
					data_q <= cmd.value;
				end
			end
			OP_DEL: begin
				if (pos >= cmd.idx) begin
					data_q <= right;
				end
			end
			OP_ROT: begin
				if (pos < cmd.idx) begin
					data_q <= right;
				end else if (pos == cmd.idx) begin
					data_q <= head;
				end
			end
			default: begin
			end
		endcase
	end

	assign data = data_q;

endmodule

### src/ple_ctrl.sv
module ple_ctrl
	import ple_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  logic [KIND_W-1:0] req_kind,
	input  logic [VALUE_W-1:0] req_value,
	input  logic [POS_W-1:0]  req_position,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output logic [STAT_W-1:0] rsp_status,
	output logic [ECNT_W-1:0] rsp_element_count,
	output logic [ELEM_W-1:0] rsp_element,
	output logic              rsp_last,
	input  data_t             head,
	output cell_cmd_t         cmd
);

	state_t            state_q;
	cnt_t              fill_q;
	cnt_t              rd_cnt_q;
	logic              out_valid_q;
	logic [STAT_W-1:0] status_q;
	logic [ECNT_W-1:0] count_q;
	logic [ELEM_W-1:0] element_q;
	logic              last_q;

	logic              load;
	logic              acc;
	logic              rsp_set;
	logic [CMP_W-1:0]  fw;
	logic [CMP_W-1:0]  pw;
	logic              full;
	logic              empty;
	stat_t             ed_stat;
	cnt_t              ed_fill;
	cell_cmd_t         ed_cmd;
	idx_t              tail_idx;
	logic              rd_last;

	assign load      = !out_valid_q || rsp_ready;
	assign req_ready = (state_q == ST_IDLE) && load;
	assign acc       = req_valid && req_ready;
	assign rsp_set   = (state_q == ST_READ) ? load :
		(acc && !(kind_t'(req_kind) == KIND_READ && !empty));
	assign fw        = CMP_W'(fill_q);
	assign pw        = CMP_W'(req_position);
	assign full      = (fill_q == cnt_t'(CAPACITY));
	assign empty     = (fill_q == '0);
	assign tail_idx  = idx_t'(fill_q - cnt_t'(1));
	assign rd_last   = (rd_cnt_q == fill_q - cnt_t'(1));

	always_comb begin
		ed_stat       = STAT_OK;
		ed_fill       = fill_q;
		ed_cmd.op     = OP_HOLD;
		ed_cmd.idx    = '0;
		ed_cmd.value  = DATA_WIDTH'(req_value);
		unique case (kind_t'(req_kind))
			KIND_INS_FRONT, KIND_INS_BACK, KIND_INS_POS: begin
				if (kind_t'(req_kind) == KIND_INS_POS && (pw == '0 || pw > fw + CMP_W'(1))) begin
					ed_stat = STAT_BADPOS;
				end else if (full) begin
					ed_stat = STAT_FULL;
				end else begin
					ed_cmd.op = OP_INS;
					ed_fill   = fill_q + cnt_t'(1);
					if (kind_t'(req_kind) == KIND_INS_FRONT) begin
						ed_cmd.idx = '0;
					end else if (kind_t'(req_kind) == KIND_INS_BACK) begin
						ed_cmd.idx = idx_t'(fill_q);
					end else begin
						ed_cmd.idx = idx_t'(pw - CMP_W'(1));
					end
				end
			end
			KIND_DEL_FRONT, KIND_DEL_BACK: begin
				if (empty) begin
					ed_stat = STAT_EMPTY;
				end else begin
					ed_cmd.op  = OP_DEL;
					ed_cmd.idx = (kind_t'(req_kind) == KIND_DEL_FRONT) ? '0 : tail_idx;
					ed_fill    = fill_q - cnt_t'(1);
				end
			end
			KIND_DEL_POS: begin
				if (pw == '0 || pw > fw) begin
					ed_stat = STAT_BADPOS;
				end else begin
					ed_cmd.op  = OP_DEL;
					ed_cmd.idx = idx_t'(pw - CMP_W'(1));
					ed_fill    = fill_q - cnt_t'(1);
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		cmd       = ed_cmd;
		cmd.op    = OP_HOLD;
		if (state_q == ST_READ) begin
			cmd.idx = tail_idx;
			cmd.op  = load ? OP_ROT : OP_HOLD;
		end else if (acc) begin
			cmd = ed_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			rd_cnt_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (rsp_set) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						if (kind_t'(req_kind) == KIND_READ && !empty) begin
							state_q  <= ST_READ;
							rd_cnt_q <= '0;
						end else begin
							fill_q <= ed_fill;
						end
					end
				end
				ST_READ: begin
					if (load) begin
						rd_cnt_q <= rd_cnt_q + cnt_t'(1);
						if (rd_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_READ && load) begin
			status_q  <= STAT_OK;
			count_q   <= ECNT_W'(fill_q);
			element_q <= ELEM_W'(head);
			last_q    <= rd_last;
		end else if (acc) begin
			status_q  <= (kind_t'(req_kind) == KIND_READ) ? STAT_EMPTY : ed_stat;
			count_q   <= ECNT_W'(ed_fill);
			element_q <= '0;
			last_q    <= 1'b1;
		end
	end

	assign rsp_valid         = out_valid_q;
	assign rsp_status        = status_q;
	assign rsp_element_count = count_q;
	assign rsp_element       = element_q;
	assign rsp_last          = last_q;

endmodule

### src/positional_list_engine.sv
// Ordered list of up to CAPACITY values kept in a row of cells. An insert or
// delete takes one request beat and shifts every cell behind the edit point in
// the same cycle, returning one response beat with the new count. A readout
// rotates the filled cells one place per cycle unless the response stalls and
// returns one beat per element, front first, holding the request side until
// the last is sent; an empty list answers with one beat. The response register
// lets a new request be taken in the cycle its previous response is taken.
module positional_list_engine
	import ple_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	ple_req_if.sink  req,
	ple_rsp_if.source rsp
);

	cell_cmd_t cmd;
	data_t     chain [CAPACITY];

	ple_ctrl u_ctrl (
		.clk               (clk),
		.arst_n            (arst_n),
		.req_valid         (req.valid),
		.req_ready         (req.ready),
		.req_kind          (req.kind),
		.req_value         (req.value),
		.req_position      (req.position),
		.rsp_valid         (rsp.valid),
		.rsp_ready         (rsp.ready),
		.rsp_status        (rsp.status),
		.rsp_element_count (rsp.element_count),
		.rsp_element       (rsp.element),
		.rsp_last          (rsp.last),
		.head              (chain[0]),
		.cmd               (cmd)
	);

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		ple_cell u_cell (
			.clk   (clk),
			.cmd   (cmd),
			.pos   (idx_t'(g)),
			.left  ((g == 0) ? data_t'(0) : chain[(g == 0) ? 0 : g - 1]),
			.right ((g == CAPACITY - 1) ? data_t'(0) : chain[(g == CAPACITY - 1) ? g : g + 1]),
			.head  (chain[0]),
			.data  (chain[g])
		);
	end

endmodule

### src/ple_checker.sv
module ple_checker
	import ple_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic [KIND_W-1:0] req_kind,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic [STAT_W-1:0] rsp_status,
	input logic [ECNT_W-1:0] rsp_element_count,
	input logic [ELEM_W-1:0] rsp_element,
	input logic              rsp_last
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_element) && $stable(rsp_last))
		else $error("response beat changed while stalled");

	a_edit_resp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_kind != KIND_READ |=> rsp_valid && rsp_last)
		else $error("edit gave no single response beat");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_element_count <= ECNT_W'(CAPACITY))
		else $error("count beyond capacity");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != STAT_OK |-> rsp_element == '0 && rsp_last)
		else $error("error beat carries an element");

endmodule

bind positional_list_engine ple_checker u_ple_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.req_kind          (req.kind),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_status        (rsp.status),
	.rsp_element_count (rsp.element_count),
	.rsp_element       (rsp.element),
	.rsp_last          (rsp.last)
);

### test/tb_positional_list_engine.sv
module tb_positional_list_engine
	import ple_pkg::*;
();

	localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;
	localparam int DIRECTED_ROWS = 28;
	localparam int RANDOM_ITEMS  = 320;
	localparam int STALL_LIMIT   = 5000;
	localparam int DRAIN_CYCLES  = 40;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [ECNT_W-1:0] count;
		logic [ELEM_W-1:0] element;
		logic              last;
	} list_beat_t;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [VALUE_W-1:0] value;
		logic [POS_W-1:0]   position;
		logic [5:0]         reps;
		bit                 typed;
		stat_t              status;
		logic [ECNT_W-1:0]  count;
	} list_row_t;

	logic clk;
	logic arst_n;
	logic steady_phase;
	int   mismatches;
	int   stall_cycles;

	data_t      shadow_cells [CAPACITY];
	int         shadow_fill;
	list_beat_t replies_due [$];
	list_row_t  script [DIRECTED_ROWS];

	ple_req_if req_ch ();
	ple_rsp_if rsp_ch ();

	positional_list_engine DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic void shadow_list_op(input logic [KIND_W-1:0] k,
			input logic [VALUE_W-1:0] v, input logic [POS_W-1:0] p);
		list_beat_t beat;
		int spot;
		int i;
		beat = '{status: STAT_OK, count: '0, element: '0, last: 1'b1};
		case (k)
		KIND_INS_FRONT, KIND_INS_BACK, KIND_INS_POS: begin
			spot = (k == KIND_INS_FRONT) ? 1 :
				(k == KIND_INS_BACK) ? shadow_fill + 1 : int'(p);
			if (spot < 1 || spot > shadow_fill + 1) begin
				beat.status = STAT_BADPOS;
			end else if (shadow_fill >= CAPACITY) begin
				beat.status = STAT_FULL;
			end else begin
				for (i = shadow_fill; i >= spot; i--)
					shadow_cells[i] = shadow_cells[i-1];
				shadow_cells[spot-1] = data_t'(v);
				shadow_fill++;
			end
		end
		KIND_DEL_FRONT, KIND_DEL_BACK, KIND_DEL_POS: begin
			spot = (k == KIND_DEL_FRONT) ? 1 :
				(k == KIND_DEL_BACK) ? shadow_fill : int'(p);
			if (shadow_fill == 0 && k != KIND_DEL_POS) begin
				beat.status = STAT_EMPTY;
			end else if (spot < 1 || spot > shadow_fill) begin
				beat.status = STAT_BADPOS;
			end else begin
				for (i = spot - 1; i < shadow_fill - 1; i++)
					shadow_cells[i] = shadow_cells[i+1];
				shadow_fill--;
			end
		end
		KIND_READ: begin
			if (shadow_fill == 0) begin
				beat.status = STAT_EMPTY;
			end else begin
				for (i = 0; i < shadow_fill; i++) begin
					beat.count   = ECNT_W'(shadow_fill);
					beat.element = ELEM_W'(shadow_cells[i]);
					beat.last    = (i == shadow_fill - 1);
					replies_due.push_back(beat);
				end
				return;
			end
		end
		default: ;
		endcase
		beat.count = ECNT_W'(shadow_fill);
		replies_due.push_back(beat);
	endfunction

	task automatic send_item(input logic [KIND_W-1:0] k, input logic [VALUE_W-1:0] v,
			input logic [POS_W-1:0] p, input bit typed, input list_beat_t typed_beat);
		if (!steady_phase) begin
			while ($urandom_range(99, 0) < 10) begin
				req_ch.valid <= 1'b0;
				@(posedge clk);
			end
		end
		req_ch.valid    <= 1'b1;
		req_ch.kind     <= k;
		req_ch.value    <= v;
		req_ch.position <= p;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		shadow_list_op(k, v, p);
		if (typed) begin
			void'(replies_due.pop_back());
			replies_due.push_back(typed_beat);
		end
	endtask

	always @(posedge clk) begin
		rsp_ch.ready <= steady_phase || ($urandom_range(99, 0) >= 10);
	end

	always @(posedge clk) begin
		list_beat_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (replies_due.size() == 0) begin
				$error("unexpected beat: status %0d element_count %0d element %h last %0b",
					rsp_ch.status, rsp_ch.element_count, rsp_ch.element, rsp_ch.last);
				mismatches++;
			end else begin
				want = replies_due.pop_front();
				if (rsp_ch.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp_ch.status);
					mismatches++;
				end
				if (rsp_ch.element_count !== want.count) begin
					$error("element_count: expected %0d, got %0d",
						want.count, rsp_ch.element_count);
					mismatches++;
				end
				if (rsp_ch.element !== want.element) begin
					$error("element: expected %h, got %h", want.element, rsp_ch.element);
					mismatches++;
				end
				if (rsp_ch.last !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, rsp_ch.last);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	initial begin
		list_row_t         row;
		list_beat_t        typed_beat;
		logic [KIND_W-1:0] k;
		logic [VALUE_W-1:0] v;
		logic [POS_W-1:0]  p;
		int                r;
		int                n;
		int                kept;
		int                roll;
		bit                growing;

		arst_n          = 1'b0;
		shadow_fill     = 0;
		steady_phase    <= 1'b0;
		req_ch.valid    <= 1'b0;
		req_ch.kind     <= KIND_INS_FRONT;
		req_ch.value    <= '0;
		req_ch.position <= '0;
		foreach (shadow_cells[i])
			shadow_cells[i] = '0;

		script = '{
			'{KIND_READ,      32'h0000_0000,  0, 1, 1, STAT_EMPTY,   0},
			'{KIND_DEL_FRONT, 32'h0000_0000,  0, 1, 1, STAT_EMPTY,   0},
			'{KIND_DEL_BACK,  32'h0000_0000,  0, 1, 1, STAT_EMPTY,   0},
			'{KIND_DEL_POS,   32'h0000_0000,  1, 1, 1, STAT_BADPOS,  0},
			'{KIND_DEL_POS,   32'h0000_0000,  0, 1, 1, STAT_BADPOS,  0},
			'{KIND_INS_POS,   32'hFFFF_FFFF,  0, 1, 1, STAT_BADPOS,  0},
			'{KIND_INS_POS,   32'h1234_5678,  2, 1, 1, STAT_BADPOS,  0},
			'{KIND_INS_POS,   32'h0000_0000,  1, 1, 1, STAT_OK,      1},
			'{KIND_INS_FRONT, 32'hFFFF_FFFF,  0, 1, 1, STAT_OK,      2},
			'{KIND_INS_BACK,  32'h8000_0001, 63, 1, 1, STAT_OK,      3},
			'{KIND_INS_POS,   32'hA5A5_A5A5,  2, 1, 0, STAT_OK,      0},
			'{KIND_INS_POS,   32'h5A5A_5A5A,  5, 1, 0, STAT_OK,      0},
			'{KIND_READ,      32'h0000_0000,  0, 1, 0, STAT_OK,      0},
			'{KIND_DEL_POS,   32'h0000_0000, 63, 1, 1, STAT_BADPOS,  5},
			'{KIND_DEL_POS,   32'h0000_0000,  6, 1, 1, STAT_BADPOS,  5},
			'{KIND_DEL_POS,   32'h0000_0000,  3, 1, 0, STAT_OK,      0},
			'{KIND_DEL_FRONT, 32'h0000_0000,  0, 1, 0, STAT_OK,      0},
			'{KIND_DEL_BACK,  32'h0000_0000,  0, 1, 0, STAT_OK,      0},
			'{KIND_UNUSED,    32'hFFFF_FFFF, 63, 1, 1, STAT_OK,      2},
			'{KIND_INS_POS,   32'h0BAD_F00D, 63, 1, 1, STAT_BADPOS,  2},
			'{KIND_INS_BACK,  32'h1000_0000,  0, 30, 0, STAT_OK,     0},
			'{KIND_INS_FRONT, 32'hDEAD_BEEF,  0, 1, 1, STAT_FULL,   32},
			'{KIND_INS_POS,   32'hDEAD_BEEF, 33, 1, 1, STAT_FULL,   32},
			'{KIND_INS_POS,   32'hDEAD_BEEF, 34, 1, 1, STAT_BADPOS, 32},
			'{KIND_INS_BACK,  32'hDEAD_BEEF,  0, 1, 1, STAT_FULL,   32},
			'{KIND_READ,      32'h0000_0000,  0, 1, 0, STAT_OK,      0},
			'{KIND_DEL_POS,   32'h0000_0000, 32, 1, 1, STAT_OK,     31},
			'{KIND_DEL_POS,   32'h0000_0000,  1, 1, 0, STAT_OK,      0}
		};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		for (r = 0; r < DIRECTED_ROWS; r++) begin
			row = script[r];
			typed_beat = '{status: row.status, count: row.count, element: '0, last: 1'b1};
			for (n = 0; n < row.reps; n++)
				send_item(row.kind, row.value + VALUE_W'(n), row.position, row.typed,
					typed_beat);
		end

		growing = 1'b1;
		kept = 0;
		while (kept < RANDOM_ITEMS) begin
			if (shadow_fill == CAPACITY && $urandom_range(3, 0) == 0)
				growing = 1'b0;
			else if (shadow_fill == 0)
				growing = 1'b1;
			roll = $urandom_range(99, 0);
			if (growing) begin
				k = (roll < 20) ? KIND_INS_FRONT : (roll < 40) ? KIND_INS_BACK :
					(roll < 62) ? KIND_INS_POS : (roll < 70) ? KIND_DEL_FRONT :
					(roll < 78) ? KIND_DEL_BACK : (roll < 88) ? KIND_DEL_POS :
					(roll < 97) ? KIND_READ : KIND_UNUSED;
			end else begin
				k = (roll < 10) ? KIND_INS_FRONT : (roll < 20) ? KIND_INS_BACK :
					(roll < 30) ? KIND_INS_POS : (roll < 50) ? KIND_DEL_FRONT :
					(roll < 70) ? KIND_DEL_BACK : (roll < 90) ? KIND_DEL_POS :
					(roll < 98) ? KIND_READ : KIND_UNUSED;
			end
			case ($urandom_range(9, 0))
			0: v = '0;
			1: v = '1;
			default: v = $urandom();
			endcase
			if ($urandom_range(99, 0) < 85)
				p = (k == KIND_INS_POS) ? POS_W'($urandom_range(shadow_fill + 1, 1)) :
					POS_W'($urandom_range((shadow_fill > 0) ? shadow_fill : 1, 1));
			else
				p = POS_W'($urandom_range(63, 0));
			if (kept == 150)
				steady_phase <= 1'b1;
			if (kept == 230)
				steady_phase <= 1'b0;
			send_item(k, v, p, 1'b0, '0);
			if (k != KIND_UNUSED)
				kept++;
		end
		req_ch.valid <= 1'b0;

		while (replies_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && replies_due.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
